### sv/mesh_vertex_normal_accumulate_macros.svh
// assertion macros for the vertex normal accumulator
`ifndef MESH_VERTEX_NORMAL_ACCUMULATE_MACROS_SVH
`define MESH_VERTEX_NORMAL_ACCUMULATE_MACROS_SVH
// same-cycle implication, clocked on clock, off during reset
`define MVA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define MVA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

### sv/mva_pkg.sv
// shared widths, codes and types of the vertex normal accumulator
package mva_pkg;
   localparam int IDX_W = 12;
   localparam int POS_W = 16;
   localparam int OUT_W = 16;
   localparam int SUM_W = 22;
   localparam int EDGE_W = POS_W + 1;
   localparam int PROD_W = 2 * EDGE_W;
   localparam int VEC_W = PROD_W + 2;
   localparam int MAG_LIM = 24;
   localparam int MAX_VERTICES_DEF = 4096;
   localparam int FRAC_BITS_DEF = 14;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_TRI = 2'd1;
   localparam logic [1:0] FUNC_READ = 2'd2;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W - 1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W - 1){1'b0}}};

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
   } pos_type;

   typedef struct packed {
      logic clip;
      logic signed [SUM_W-1:0] x;
      logic signed [SUM_W-1:0] y;
      logic signed [SUM_W-1:0] z;
   } sum_type;

   typedef struct packed {
      logic pos_rd;
      logic pos_wr;
      logic sum_rd;
      logic sum_wr;
   } mem_ctl_type;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_WRITE, ST_POS_A, ST_POS_B, ST_POS_C, ST_EDGE, ST_CROSS,
      ST_NORM_GO, ST_NORM_WAIT, ST_READ, ST_READ_GO, ST_SUM_RD, ST_SUM_WR, ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      N_IDLE, N_SHIFT, N_SQUARE, N_ROOT, N_DIV_INIT, N_DIV, N_DONE
   } norm_state_type;
endpackage

### sv/mesh_vertex_normal_accumulate.sv
// top level: item sequencer, cross product, sum update and result register
//  channel | dir | handshake            | payload
//  req     | in  | req_valid/req_ready  | func, vertex_index, pos_x/y/z, corner_a/b/c
//  rsp     | out | rsp_valid/rsp_ready  | normal_x/y/z, which_vertex, zero_sum, clipped
// after reset a clearing pass zeroes the sums, with req_ready low
// one item at a time: a readout and a triangle wait on the serial range shift, root
// and divide of the normaliser, and a triangle also on the three sum read-modify-writes
// on one port
// a waiting result holds the next result in ST_OUT and so holds back the next item's acceptance
`include "mesh_vertex_normal_accumulate_macros.svh"
module mesh_vertex_normal_accumulate import mva_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_func,
   input  logic [IDX_W-1:0] req_vertex_index,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic signed [POS_W-1:0] req_pos_z,
   input  logic [IDX_W-1:0] req_corner_a,
   input  logic [IDX_W-1:0] req_corner_b,
   input  logic [IDX_W-1:0] req_corner_c,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [OUT_W-1:0] rsp_normal_x,
   output logic signed [OUT_W-1:0] rsp_normal_y,
   output logic signed [OUT_W-1:0] rsp_normal_z,
   output logic [IDX_W-1:0] rsp_which_vertex,
   output logic rsp_zero_sum,
   output logic rsp_clipped
);
   localparam int AW = $clog2(MAX_VERTICES);
   localparam int NRM_W = FRAC_BITS + 2;
   localparam int SADD_W = SUM_W + 2;

   function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
      return int'(idx) < MAX_VERTICES;
   endfunction

   function automatic logic signed [SUM_W-1:0] sat(input logic signed [SADD_W-1:0] s);
      if (s > SADD_W'(SUM_MAX)) return SUM_MAX;
      if (s < SADD_W'(SUM_MIN)) return SUM_MIN;
      return SUM_W'(s);
   endfunction

   function automatic logic ovf(input logic signed [SADD_W-1:0] s);
      return (s > SADD_W'(SUM_MAX)) || (s < SADD_W'(SUM_MIN));
   endfunction

   state_type state_ff, state_in;
   logic [AW-1:0] clr_ff;
   logic [1:0] func_ff;
   logic [IDX_W-1:0] vidx_ff, ca_ff, cb_ff, cc_ff;
   pos_type wpos_ff, pa_ff, pb_ff;
   logic signed [EDGE_W-1:0] e1_ff [3];
   logic signed [EDGE_W-1:0] e2_ff [3];
   logic [2:0] cnt_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [VEC_W-1:0] cr_ff [3];
   logic [1:0] corner_ff;
   logic clip_ff, clipm_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0] rsp_nx_ff, rsp_ny_ff, rsp_nz_ff;
   logic [IDX_W-1:0] rsp_who_ff;
   logic rsp_zero_ff, rsp_clip_ff;

   mem_ctl_type mem_ctl;
   logic [AW-1:0] mem_addr;
   sum_type sum_wdata;
   pos_type pos_q, pc;
   sum_type sum_q;
   logic norm_start, norm_done, norm_zero;
   logic signed [VEC_W-1:0] norm_vec [3];
   logic signed [NRM_W-1:0] nrm_n [3];
   logic [IDX_W-1:0] cur_idx;
   logic cur_ok, vidx_ok, out_load;
   logic signed [EDGE_W-1:0] op_a, op_b;
   logic [1:0] cr_k;
   logic signed [SADD_W-1:0] sx, sy, sz;

   mva_mem #(.MAX_VERTICES(MAX_VERTICES)) u_mem (
      .clock(clock), .ctl(mem_ctl), .addr(mem_addr), .pos_wdata(wpos_ff),
      .sum_wdata(sum_wdata), .pos_q_ff(pos_q), .sum_q_ff(sum_q)
   );

   mva_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
      .clock(clock), .reset(reset), .start(norm_start), .vec(norm_vec),
      .done(norm_done), .zero(norm_zero), .nrm(nrm_n)
   );

   always_comb begin
      vidx_ok = idx_ok(vidx_ff);
      cur_idx = (corner_ff == 2'd0) ? ca_ff : ((corner_ff == 2'd1) ? cb_ff : cc_ff);
      cur_ok = idx_ok(cur_idx);
      pc = idx_ok(cc_ff) ? pos_q : '0;
      cr_k = 2'((cnt_ff - 3'd1) >> 1);
      out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
      sx = SADD_W'(sum_q.x) + SADD_W'(nrm_n[0]);
      sy = SADD_W'(sum_q.y) + SADD_W'(nrm_n[1]);
      sz = SADD_W'(sum_q.z) + SADD_W'(nrm_n[2]);
      norm_vec[0] = (func_ff == FUNC_TRI) ? cr_ff[0] : VEC_W'(sum_q.x);
      norm_vec[1] = (func_ff == FUNC_TRI) ? cr_ff[1] : VEC_W'(sum_q.y);
      norm_vec[2] = (func_ff == FUNC_TRI) ? cr_ff[2] : VEC_W'(sum_q.z);
      // cross product terms in the order yz zy zx xz xy yx
      unique case (cnt_ff)
         3'd0:    begin op_a = e1_ff[1]; op_b = e2_ff[2]; end
         3'd1:    begin op_a = e1_ff[2]; op_b = e2_ff[1]; end
         3'd2:    begin op_a = e1_ff[2]; op_b = e2_ff[0]; end
         3'd3:    begin op_a = e1_ff[0]; op_b = e2_ff[2]; end
         3'd4:    begin op_a = e1_ff[0]; op_b = e2_ff[1]; end
         3'd5:    begin op_a = e1_ff[1]; op_b = e2_ff[0]; end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:     if (clr_ff == AW'(MAX_VERTICES - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) begin
               priority case (req_func)
                  FUNC_WRITE: state_in = ST_WRITE;
                  FUNC_TRI:   state_in = ST_POS_A;
                  FUNC_READ:  state_in = ST_READ;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_WRITE:     state_in = ST_IDLE;
         ST_POS_A:     state_in = ST_POS_B;
         ST_POS_B:     state_in = ST_POS_C;
         ST_POS_C:     state_in = ST_EDGE;
         ST_EDGE:      state_in = ST_CROSS;
         ST_CROSS:     if (cnt_ff == 3'd6) state_in = ST_NORM_GO;
         ST_NORM_GO:   state_in = ST_NORM_WAIT;
         ST_NORM_WAIT: begin
            if (norm_done) begin
               state_in = (func_ff == FUNC_TRI && !norm_zero) ? ST_SUM_RD : ST_OUT;
            end
         end
         ST_READ:      state_in = ST_READ_GO;
         ST_READ_GO:   state_in = vidx_ok ? ST_NORM_WAIT : ST_OUT;
         ST_SUM_RD: begin
            if (cur_ok) state_in = ST_SUM_WR;
            else if (corner_ff == 2'd2) state_in = ST_OUT;
         end
         ST_SUM_WR:    state_in = (corner_ff == 2'd2) ? ST_OUT : ST_SUM_RD;
         ST_OUT:       if (out_load) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mem_ctl = '0;
      mem_addr = AW'(vidx_ff);
      norm_start = 1'b0;
      sum_wdata = '0;
      req_ready = state_ff == ST_IDLE;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_ctl.sum_wr = 1'b1;
            mem_addr = clr_ff;
         end
         ST_WRITE: begin
            mem_ctl.pos_wr = vidx_ok;
            mem_ctl.sum_wr = vidx_ok;
         end
         ST_POS_A: begin
            mem_ctl.pos_rd = 1'b1;
            mem_addr = AW'(ca_ff);
         end
         ST_POS_B: begin
            mem_ctl.pos_rd = 1'b1;
            mem_addr = AW'(cb_ff);
         end
         ST_POS_C: begin
            mem_ctl.pos_rd = 1'b1;
            mem_addr = AW'(cc_ff);
         end
         ST_READ:    mem_ctl.sum_rd = vidx_ok;
         ST_READ_GO: norm_start = vidx_ok;
         ST_NORM_GO: norm_start = 1'b1;
         ST_SUM_RD: begin
            mem_ctl.sum_rd = cur_ok;
            mem_addr = AW'(cur_idx);
         end
         ST_SUM_WR: begin
            mem_ctl.sum_wr = 1'b1;
            mem_addr = AW'(cur_idx);
            sum_wdata.x = sat(sx);
            sum_wdata.y = sat(sy);
            sum_wdata.z = sat(sz);
            sum_wdata.clip = sum_q.clip | ovf(sx) | ovf(sy) | ovf(sz);
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_ff <= req_func;
               vidx_ff <= req_vertex_index;
               wpos_ff <= '{x: req_pos_x, y: req_pos_y, z: req_pos_z};
               ca_ff <= req_corner_a;
               cb_ff <= req_corner_b;
               cc_ff <= req_corner_c;
               clip_ff <= 1'b0;
            end
         end
         ST_POS_B: pa_ff <= idx_ok(ca_ff) ? pos_q : '0;
         ST_POS_C: pb_ff <= idx_ok(cb_ff) ? pos_q : '0;
         ST_EDGE: begin
            e1_ff[0] <= EDGE_W'(pb_ff.x) - EDGE_W'(pa_ff.x);
            e1_ff[1] <= EDGE_W'(pb_ff.y) - EDGE_W'(pa_ff.y);
            e1_ff[2] <= EDGE_W'(pb_ff.z) - EDGE_W'(pa_ff.z);
            e2_ff[0] <= EDGE_W'(pc.x) - EDGE_W'(pa_ff.x);
            e2_ff[1] <= EDGE_W'(pc.y) - EDGE_W'(pa_ff.y);
            e2_ff[2] <= EDGE_W'(pc.z) - EDGE_W'(pa_ff.z);
            for (int i = 0; i < 3; i++) begin
               cr_ff[i] <= '0;
            end
            cnt_ff <= 3'd0;
         end
         ST_CROSS: begin
            if (cnt_ff != 3'd6) prod_ff <= op_a * op_b;
            // the product is registered and used at the next count: odd counts add, even counts subtract
            if (cnt_ff != 3'd0) begin
               if (cnt_ff[0]) cr_ff[cr_k] <= cr_ff[cr_k] + VEC_W'(prod_ff);
               else cr_ff[cr_k] <= cr_ff[cr_k] - VEC_W'(prod_ff);
            end
            cnt_ff <= cnt_ff + 3'd1;
         end
         ST_NORM_WAIT: corner_ff <= 2'd0;
         ST_READ_GO:   clipm_ff <= vidx_ok & sum_q.clip;
         ST_SUM_RD:    if (!cur_ok) corner_ff <= corner_ff + 2'd1;
         ST_SUM_WR: begin
            corner_ff <= corner_ff + 2'd1;
            if (ovf(sx) || ovf(sy) || ovf(sz)) clip_ff <= 1'b1;
         end
         ST_OUT: begin
            if (out_load) begin
               if (func_ff == FUNC_READ && !vidx_ok) begin
                  rsp_nx_ff <= '0;
                  rsp_ny_ff <= '0;
                  rsp_nz_ff <= '0;
                  rsp_zero_ff <= 1'b1;
               end else begin
                  rsp_nx_ff <= OUT_W'(nrm_n[0]);
                  rsp_ny_ff <= OUT_W'(nrm_n[1]);
                  rsp_nz_ff <= OUT_W'(nrm_n[2]);
                  rsp_zero_ff <= norm_zero;
               end
               rsp_who_ff <= (func_ff == FUNC_TRI) ? ca_ff : vidx_ff;
               rsp_clip_ff <= (func_ff == FUNC_TRI) ? clip_ff : clipm_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_normal_x = rsp_nx_ff;
   assign rsp_normal_y = rsp_ny_ff;
   assign rsp_normal_z = rsp_nz_ff;
   assign rsp_which_vertex = rsp_who_ff;
   assign rsp_zero_sum = rsp_zero_ff;
   assign rsp_clipped = rsp_clip_ff;

   `MVA_ASSERT_NOW(a_rsp_from_out, $rose(rsp_valid), $past(state_ff == ST_OUT), "result without output state")
   `MVA_ASSERT_NOW(a_rmw_addr, state_ff == ST_SUM_WR, $past(mem_ctl.sum_rd) && $stable(mem_addr), "sum write-back not paired with its read")
   `MVA_ASSERT_NOW(a_write_clears, mem_ctl.pos_wr, mem_ctl.sum_wr, "vertex write without sum clear")
   `MVA_ASSERT_NEXT(a_norm_start_idle, norm_start, !norm_done, "normaliser done straight after start")
endmodule

### sv/mva_mem.sv
// position and normal-sum memories, one shared address, registered reads
module mva_mem import mva_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   localparam int AW = $clog2(MAX_VERTICES)
) (
   input  logic        clock,
   input  mem_ctl_type ctl,
   input  logic [AW-1:0] addr,
   input  pos_type     pos_wdata,
   input  sum_type     sum_wdata,
   output pos_type     pos_q_ff,
   output sum_type     sum_q_ff
);
   pos_type pos_mem [MAX_VERTICES];
   sum_type sum_mem [MAX_VERTICES];

   always_ff @(posedge clock) begin
      if (ctl.pos_wr) begin
         pos_mem[addr] <= pos_wdata;
      end
      if (ctl.pos_rd) begin
         pos_q_ff <= pos_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.sum_wr) begin
         sum_mem[addr] <= sum_wdata;
      end
      if (ctl.sum_rd) begin
         sum_q_ff <= sum_mem[addr];
      end
   end
endmodule

### sv/mva_norm.sv
// bit-serial vector normaliser: range shift, squares, integer root, divides
module mva_norm import mva_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   localparam int NRM_W = FRAC_BITS + 2
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [VEC_W-1:0] vec [3],
   output logic done,
   output logic zero,
   output logic signed [NRM_W-1:0] nrm [3]
);
   localparam int SQ_W = 2 * MAG_LIM + 2;
   localparam int RT_W = MAG_LIM + 1;
   localparam int QB = FRAC_BITS + 2;
   localparam int DIV_W = MAG_LIM + FRAC_BITS + 3;
   localparam int STEP_W = $clog2(QB);
   localparam logic [SQ_W-1:0] BIT_INIT = SQ_W'(1) << (2 * MAG_LIM);
   localparam logic [QB-1:0] ONE = QB'(1) << FRAC_BITS;

   norm_state_type st_ff, st_in;
   logic [VEC_W-1:0] m_ff [3];
   logic neg_ff [3];
   logic [1:0] idx_ff;
   logic [2*MAG_LIM-1:0] sqp_ff;
   logic [SQ_W-1:0] v_ff, res_ff, bit_ff;
   logic [DIV_W-1:0] rem_ff, dsh_ff;
   logic [QB-1:0] quo_ff;
   logic [STEP_W-1:0] step_ff;
   logic zero_ff;
   logic signed [NRM_W-1:0] nrm_ff [3];

   logic [VEC_W-1:0] mag_or, msel;
   logic big, take, rem_ge, root_last, div_last;
   logic [SQ_W:0] trial;
   logic [SQ_W-1:0] res_nx;
   logic [RT_W-1:0] q;
   logic [QB-1:0] quo_nx, rclamp;
   logic signed [NRM_W-1:0] rpos, nval;

   always_comb begin
      mag_or = m_ff[0] | m_ff[1] | m_ff[2];
      big = |mag_or[VEC_W-1:MAG_LIM];
      msel = (idx_ff == 2'd3) ? '0 : m_ff[idx_ff];
      trial = (SQ_W + 1)'(res_ff) + (SQ_W + 1)'(bit_ff);
      take = {1'b0, v_ff} >= trial;
      res_nx = take ? (res_ff >> 1) + bit_ff : res_ff >> 1;
      root_last = bit_ff == SQ_W'(1);
      q = res_ff[RT_W-1:0];
      rem_ge = rem_ff >= dsh_ff;
      quo_nx = {quo_ff[QB-2:0], rem_ge};
      div_last = step_ff == STEP_W'(QB - 1);
      rclamp = (quo_nx > ONE) ? ONE : quo_nx;
      rpos = NRM_W'(rclamp);
      nval = (idx_ff != 2'd3 && neg_ff[idx_ff]) ? -rpos : rpos;
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         N_IDLE:     if (start) st_in = N_SHIFT;
         N_SHIFT:    if (!big) st_in = N_SQUARE;
         N_SQUARE:   if (idx_ff == 2'd3) st_in = N_ROOT;
         N_ROOT:     if (root_last) st_in = (res_nx == '0) ? N_DONE : N_DIV_INIT;
         N_DIV_INIT: st_in = N_DIV;
         N_DIV:      if (div_last) st_in = (idx_ff == 2'd2) ? N_DONE : N_DIV_INIT;
         N_DONE:     st_in = N_IDLE;
         default:    st_in = N_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= N_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (st_ff)
         N_IDLE: begin
            if (start) begin
               for (int i = 0; i < 3; i++) begin
                  neg_ff[i] <= vec[i] < 0;
                  m_ff[i] <= (vec[i] < 0) ? VEC_W'(-vec[i]) : VEC_W'(vec[i]);
               end
            end
         end
         N_SHIFT: begin
            if (big) begin
               for (int i = 0; i < 3; i++) begin
                  m_ff[i] <= m_ff[i] >> 1;
               end
            end else begin
               idx_ff <= 2'd0;
               v_ff <= '0;
            end
         end
         N_SQUARE: begin
            if (idx_ff != 2'd3) begin
               sqp_ff <= msel[MAG_LIM-1:0] * msel[MAG_LIM-1:0];
            end
            if (idx_ff != 2'd0) begin
               v_ff <= v_ff + SQ_W'(sqp_ff);
            end
            if (idx_ff == 2'd3) begin
               res_ff <= '0;
               bit_ff <= BIT_INIT;
            end
            idx_ff <= idx_ff + 2'd1;
         end
         N_ROOT: begin
            if (take) begin
               v_ff <= v_ff - trial[SQ_W-1:0];
            end
            res_ff <= res_nx;
            bit_ff <= bit_ff >> 2;
            if (root_last) begin
               zero_ff <= res_nx == '0;
               if (res_nx == '0) begin
                  for (int i = 0; i < 3; i++) begin
                     nrm_ff[i] <= '0;
                  end
               end
            end
         end
         N_DIV_INIT: begin
            // numerator m*2^(f+1)+q over 2q rounds half up
            rem_ff <= (DIV_W'(msel[MAG_LIM-1:0]) << (FRAC_BITS + 1)) + DIV_W'(q);
            dsh_ff <= DIV_W'({q, 1'b0}) << (QB - 1);
            quo_ff <= '0;
            step_ff <= '0;
         end
         N_DIV: begin
            if (rem_ge) begin
               rem_ff <= rem_ff - dsh_ff;
            end
            dsh_ff <= dsh_ff >> 1;
            quo_ff <= quo_nx;
            step_ff <= step_ff + STEP_W'(1);
            if (div_last) begin
               nrm_ff[idx_ff] <= nval;
               idx_ff <= idx_ff + 2'd1;
            end
         end
         N_DONE: ;
         default: ;
      endcase
   end

   assign done = st_ff == N_DONE;
   assign zero = zero_ff;
   assign nrm = nrm_ff;
endmodule

### dv/mesh_vertex_normal_accumulate_tb.sv
// testbench: vertex normal accumulator driven with random meshes, checked against a predictor
module mesh_vertex_normal_accumulate_tb import mva_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] FUNC_NONE = 2'd3;
   localparam int FRAC = FRAC_BITS_DEF;
   localparam int NVTX = MAX_VERTICES_DEF;

   typedef struct {
      logic [1:0] func;
      logic [IDX_W-1:0] vertex;
      logic signed [POS_W-1:0] px, py, pz;
      logic [IDX_W-1:0] ca, cb, cc;
   } mesh_item_type;

   typedef struct {
      logic signed [OUT_W-1:0] nx, ny, nz;
      logic [IDX_W-1:0] vertex;
      logic zero;
      logic clip;
   } normal_result_type;

   class normal_board;
      pos_type pos_mem[NVTX];
      logic signed [SUM_W-1:0] sum_x[NVTX], sum_y[NVTX], sum_z[NVTX];
      bit clip_mem[NVTX];
      normal_result_type due[$];
      int errors;

      function new();
         foreach (sum_x[i]) begin
            pos_mem[i] = '0;
            sum_x[i] = '0;
            sum_y[i] = '0;
            sum_z[i] = '0;
            clip_mem[i] = 0;
         end
         errors = 0;
      endfunction

      // scale down to below 2^24, integer root, rounded divide per component
      function bit make_unit(input longint vx, vy, vz,
                             output logic signed [OUT_W-1:0] ox, oy, oz);
         longint unsigned m[3];
         longint unsigned big, sq, q, res, bitv, r;
         longint v[3];
         v[0] = vx;
         v[1] = vy;
         v[2] = vz;
         for (int i = 0; i < 3; i++) m[i] = (v[i] < 0) ? -v[i] : v[i];
         forever begin
            big = m[0];
            if (m[1] > big) big = m[1];
            if (m[2] > big) big = m[2];
            if (big < (64'd1 << MAG_LIM)) break;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
         end
         sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > sq) bitv >>= 2;
         while (bitv != 0) begin
            if (sq >= res + bitv) begin
               sq -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         q = res;
         ox = '0;
         oy = '0;
         oz = '0;
         if (q == 0) return 1;
         for (int i = 0; i < 3; i++) begin
            r = ((m[i] << FRAC) * 2 + q) / (2 * q);
            if (r > (64'd1 << FRAC)) r = 64'd1 << FRAC;
            if (v[i] < 0) r = -r;
            case (i)
               0: ox = r[OUT_W-1:0];
               1: oy = r[OUT_W-1:0];
               default: oz = r[OUT_W-1:0];
            endcase
         end
         return 0;
      endfunction

      function logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                                input logic signed [OUT_W-1:0] n,
                                                inout bit cl);
         longint t;
         t = longint'(s) + longint'(n);
         if (t > longint'(SUM_MAX)) begin
            cl = 1;
            return SUM_MAX;
         end
         if (t < longint'(SUM_MIN)) begin
            cl = 1;
            return SUM_MIN;
         end
         return t[SUM_W-1:0];
      endfunction

      function void note_item(mesh_item_type it);
         normal_result_type e;
         longint p[3][3], e1[3], e2[3];
         logic [IDX_W-1:0] c[3];
         bit cl;
         e.clip = 0;
         case (it.func)
            FUNC_WRITE: begin
               pos_mem[it.vertex] = '{x: it.px, y: it.py, z: it.pz};
               sum_x[it.vertex] = '0;
               sum_y[it.vertex] = '0;
               sum_z[it.vertex] = '0;
               clip_mem[it.vertex] = 0;
            end
            FUNC_TRI: begin
               c[0] = it.ca;
               c[1] = it.cb;
               c[2] = it.cc;
               for (int i = 0; i < 3; i++) begin
                  p[i][0] = longint'(pos_mem[c[i]].x);
                  p[i][1] = longint'(pos_mem[c[i]].y);
                  p[i][2] = longint'(pos_mem[c[i]].z);
               end
               for (int k = 0; k < 3; k++) begin
                  e1[k] = p[1][k] - p[0][k];
                  e2[k] = p[2][k] - p[0][k];
               end
               e.zero = make_unit(e1[1] * e2[2] - e1[2] * e2[1],
                                  e1[2] * e2[0] - e1[0] * e2[2],
                                  e1[0] * e2[1] - e1[1] * e2[0], e.nx, e.ny, e.nz);
               if (!e.zero) begin
                  for (int i = 0; i < 3; i++) begin
                     cl = 0;
                     sum_x[c[i]] = sat_add(sum_x[c[i]], e.nx, cl);
                     sum_y[c[i]] = sat_add(sum_y[c[i]], e.ny, cl);
                     sum_z[c[i]] = sat_add(sum_z[c[i]], e.nz, cl);
                     if (cl) begin
                        clip_mem[c[i]] = 1;
                        e.clip = 1;
                     end
                  end
               end
               e.vertex = it.ca;
               due = {due, e};
            end
            FUNC_READ: begin
               e.zero = make_unit(longint'(sum_x[it.vertex]), longint'(sum_y[it.vertex]),
                                  longint'(sum_z[it.vertex]), e.nx, e.ny, e.nz);
               e.clip = clip_mem[it.vertex];
               e.vertex = it.vertex;
               due = {due, e};
            end
            default: ;
         endcase
      endfunction

      function void compare(string name, longint want, longint got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(normal_result_type got);
         normal_result_type e;
         if (due.size() == 0) begin
            $display("%0t: result with none expected, vertex %0d", $time, got.vertex);
            errors++;
            return;
         end
         e = due.pop_front();
         compare("normal_x", longint'(e.nx), longint'(got.nx));
         compare("normal_y", longint'(e.ny), longint'(got.ny));
         compare("normal_z", longint'(e.nz), longint'(got.nz));
         compare("which_vertex", longint'(e.vertex), longint'(got.vertex));
         compare("zero_sum", longint'(e.zero), longint'(got.zero));
         compare("clipped", longint'(e.clip), longint'(got.clip));
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [1:0] req_func = '0;
   logic [IDX_W-1:0] req_vertex_index = '0;
   logic signed [POS_W-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [IDX_W-1:0] req_corner_a = '0, req_corner_b = '0, req_corner_c = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [OUT_W-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic [IDX_W-1:0] rsp_which_vertex;
   logic rsp_zero_sum, rsp_clipped;

   normal_board board = new();
   int sent = 0;
   bit req_rush = 0, rsp_rush = 0;
   logic [IDX_W-1:0] placed[$];

   always #5 clock = ~clock;

   mesh_vertex_normal_accumulate i_dut (.*);

   // entered and left just after a falling edge
   task automatic push(mesh_item_type it);
      int gap;
      if ($urandom_range(0, 39) == 0) req_rush = ~req_rush;
      gap = req_rush ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_func = it.func;
      req_vertex_index = it.vertex;
      req_pos_x = it.px;
      req_pos_y = it.py;
      req_pos_z = it.pz;
      req_corner_a = it.ca;
      req_corner_b = it.cb;
      req_corner_c = it.cc;
      req_valid = 1;
      do @(posedge clock); while (!req_ready);
      board.note_item(it);
      sent++;
      @(negedge clock);
   endtask

   function automatic mesh_item_type noise_item(logic [1:0] func);
      mesh_item_type it;
      it.func = func;
      it.vertex = IDX_W'($urandom);
      it.px = POS_W'($urandom);
      it.py = POS_W'($urandom);
      it.pz = POS_W'($urandom);
      it.ca = IDX_W'($urandom);
      it.cb = IDX_W'($urandom);
      it.cc = IDX_W'($urandom);
      return it;
   endfunction

   task automatic write_vertex(logic [IDX_W-1:0] v, logic signed [POS_W-1:0] x, y, z);
      mesh_item_type it;
      it = noise_item(FUNC_WRITE);
      it.vertex = v;
      it.px = x;
      it.py = y;
      it.pz = z;
      if (!(v inside {placed})) placed = {placed, v};
      push(it);
   endtask

   task automatic add_triangle(logic [IDX_W-1:0] a, b, c);
      mesh_item_type it;
      it = noise_item(FUNC_TRI);
      it.ca = a;
      it.cb = b;
      it.cc = c;
      push(it);
   endtask

   task automatic read_normal(logic [IDX_W-1:0] v);
      mesh_item_type it;
      it = noise_item(FUNC_READ);
      it.vertex = v;
      push(it);
   endtask

   function automatic logic signed [POS_W-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 16'sh7fff;
         1: return -16'sh8000;
         2: return POS_W'(int'($urandom_range(0, 64)) - 32);
         default: return POS_W'($urandom);
      endcase
   endfunction

   function automatic logic [IDX_W-1:0] pick_placed();
      return placed[$urandom_range(0, placed.size() - 1)];
   endfunction

   // result side: random stalls, sampled at the rising edge
   initial begin
      normal_result_type got;
      int stall;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_rush = ~rsp_rush;
         stall = rsp_rush ? 0 : $urandom_range(0, 13);
         if (stall != 0) begin
            rsp_ready = 0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1;
         do @(posedge clock); while (!rsp_valid);
         got.nx = rsp_normal_x;
         got.ny = rsp_normal_y;
         got.nz = rsp_normal_z;
         got.vertex = rsp_which_vertex;
         got.zero = rsp_zero_sum;
         got.clip = rsp_clipped;
         board.check_result(got);
         @(negedge clock);
      end
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      logic [IDX_W-1:0] pool[$];
      logic [IDX_W-1:0] a, b, c;
      int n;
      logic signed [POS_W-1:0] plane;
      repeat (9) @(negedge clock);
      reset = 0;

      // directed: extremes, degenerate faces, untouched vertex, unknown func
      write_vertex(0, 0, 0, 0);
      write_vertex(4095, 16'sh7fff, -16'sh8000, 16'sh7fff);
      write_vertex(1, -16'sh8000, 16'sh7fff, -16'sh8000);
      write_vertex(2, 16'sh4000, 0, 0);
      write_vertex(3, 0, 16'sh4000, 0);
      add_triangle(0, 2, 3);
      add_triangle(0, 4095, 1);
      add_triangle(4095, 1, 2);
      add_triangle(2, 2, 3);
      add_triangle(0, 0, 0);
      read_normal(0);
      read_normal(2);
      read_normal(4095);
      read_normal(2048);
      push(noise_item(FUNC_NONE));
      write_vertex(2, 16'sh4000, 0, 0);
      read_normal(2);
      add_triangle(3, 0, 2);
      read_normal(3);
      read_normal(0);

      while (sent < 1700) begin
         if ($urandom_range(0, 15) == 0) begin
            // same face many times over can drive the corner sums into saturation
            a = pick_placed();
            b = pick_placed();
            c = pick_placed();
            n = $urandom_range(130, 160);
            repeat (n) add_triangle(a, b, c);
            read_normal(a);
            read_normal(b);
            read_normal(c);
         end else begin
            pool.delete();
            plane = rand_coord();
            n = $urandom_range(3, 12);
            repeat (n) begin
               case ($urandom_range(0, 9))
                  0: a = 0;
                  1: a = 4095;
                  default: a = IDX_W'($urandom);
               endcase
               pool = {pool, a};
               if ($urandom_range(0, 2) == 0)
                  write_vertex(a, rand_coord(), rand_coord(), plane);
               else
                  write_vertex(a, rand_coord(), rand_coord(), rand_coord());
            end
            n = $urandom_range(10, 40);
            repeat (n) begin
               case ($urandom_range(0, 19))
                  0: push(noise_item(FUNC_NONE));
                  1: write_vertex(pool[$urandom_range(0, pool.size() - 1)],
                                  rand_coord(), rand_coord(), rand_coord());
                  2: add_triangle(pick_placed(), pick_placed(), pick_placed());
                  3, 4, 5: read_normal($urandom_range(0, 3) == 0 ?
                                       12'($urandom) : pool[$urandom_range(0, pool.size() - 1)]);
                  default: add_triangle(pool[$urandom_range(0, pool.size() - 1)],
                                        pool[$urandom_range(0, pool.size() - 1)],
                                        pool[$urandom_range(0, pool.size() - 1)]);
               endcase
            end
         end
      end
      req_valid = 0;
      while (board.due.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (board.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
